// ----- hw/rtl/dsdt_pkg.sv -----
// package: types, constants and tables for the dark scene denoise trigger
`timescale 1ns / 1ps
package dsdt_pkg;

	typedef enum logic [2:0] {
		MODE_BRIGHT = 3'd0,
		MODE_ARMING = 3'd1,
		MODE_RAMP   = 3'd2,
		MODE_ACTIVE = 3'd3,
		MODE_EXITP  = 3'd4,
		MODE_ERROR  = 3'd5
	} mode_t;

	localparam int ARM_FRAMES_DEF  = 3;
	localparam int EXIT_FRAMES_DEF = 10;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_ENTER_SCORE_MIN = 3'd0;
	localparam logic [2:0] REG_EXIT_SCORE_MAX  = 3'd1;
	localparam logic [2:0] REG_ENTER_ISO_MIN   = 3'd2;
	localparam logic [2:0] REG_EXIT_ISO_MAX    = 3'd3;
	localparam logic [2:0] REG_ENTER_EV_MAX    = 3'd4;
	localparam logic [2:0] REG_EXIT_EV_MIN     = 3'd5;
	localparam logic [2:0] REG_ENTER_NOISE_MIN = 3'd6;
	localparam logic [2:0] REG_EXIT_NOISE_MAX  = 3'd7;

	localparam logic [7:0]  ENTER_SCORE_MIN_RST = 8'd179;
	localparam logic [7:0]  EXIT_SCORE_MAX_RST  = 8'd115;
	localparam logic [15:0] ENTER_ISO_MIN_RST   = 16'd1600;
	localparam logic [15:0] EXIT_ISO_MAX_RST    = 16'd1200;
	localparam logic [7:0]  ENTER_EV_MAX_RST    = 8'hE8;
	localparam logic [7:0]  EXIT_EV_MIN_RST     = 8'hF0;
	localparam logic [11:0] ENTER_NOISE_MIN_RST = 12'd82;
	localparam logic [11:0] EXIT_NOISE_MAX_RST  = 12'd61;

	localparam logic [2:0] RAMP_LEN      = 3'd5;
	localparam logic [8:0] STRENGTH_FULL = 9'd256;

	// strength ramp 0.2 .. 1.0 in q1.8
	function automatic logic [8:0] ramp_strength(input logic [2:0] idx);
		logic [8:0] s;
		case (idx)
			3'd0:    s = 9'd51;
			3'd1:    s = 9'd102;
			3'd2:    s = 9'd154;
			3'd3:    s = 9'd205;
			3'd4:    s = 9'd256;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ----- hw/rtl/dark_scene_denoise_trigger_unit.sv -----
// top level: dark scene denoise trigger with apb register file
`timescale 1ns / 1ps
// Takes one frame of metadata per transaction and returns one decision per
// transaction (bypass, strength in q1.8, mode). An accepted frame lands in an
// input register; the decision and the state update are made from it and written
// to an output register, so one frame is taken every clock while the
// output side is ready. Invalid metadata, a camera transition or thermal bypass
// sends the block to a sticky error mode that only reset clears. Thresholds sit
// on the APB port at byte offsets 0x00..0x1c and must be changed only while no
// frame is in flight.
module dark_scene_denoise_trigger_unit #(
	parameter int ARM_FRAMES  = dsdt_pkg::ARM_FRAMES_DEF,
	parameter int EXIT_FRAMES = dsdt_pkg::EXIT_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dsdt_pkg::ADDR_W-1:0] paddr,
	input  logic [dsdt_pkg::DATA_W-1:0] pwdata,
	output logic [dsdt_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        meta_valid,
	input  logic                        cam_switch,
	input  logic                        thermal_off,
	input  logic                        score_present,
	input  logic [7:0]                  dark_level,
	input  logic [15:0]                 iso_gain,
	input  logic signed [7:0]           exposure_ev,
	input  logic [11:0]                 noise_est,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        bypass,
	output logic [8:0]                  strength,
	output logic [2:0]                  mode
);
	import dsdt_pkg::*;

	localparam logic [1:0] ARM_LIM  = 2'(ARM_FRAMES);
	localparam logic [3:0] EXIT_LIM = 4'(EXIT_FRAMES);

	// configuration registers
	logic [7:0]        enter_score_min_q, exit_score_max_q;
	logic [15:0]       enter_iso_min_q, exit_iso_max_q;
	logic signed [7:0] enter_ev_max_q, exit_ev_min_q;
	logic [11:0]       enter_noise_min_q, exit_noise_max_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_score_min_q <= ENTER_SCORE_MIN_RST;
			exit_score_max_q  <= EXIT_SCORE_MAX_RST;
			enter_iso_min_q   <= ENTER_ISO_MIN_RST;
			exit_iso_max_q    <= EXIT_ISO_MAX_RST;
			enter_ev_max_q    <= ENTER_EV_MAX_RST;
			exit_ev_min_q     <= EXIT_EV_MIN_RST;
			enter_noise_min_q <= ENTER_NOISE_MIN_RST;
			exit_noise_max_q  <= EXIT_NOISE_MAX_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ENTER_SCORE_MIN: enter_score_min_q <= pwdata[7:0];
				REG_EXIT_SCORE_MAX:  exit_score_max_q  <= pwdata[7:0];
				REG_ENTER_ISO_MIN:   enter_iso_min_q   <= pwdata[15:0];
				REG_EXIT_ISO_MAX:    exit_iso_max_q    <= pwdata[15:0];
				REG_ENTER_EV_MAX:    enter_ev_max_q    <= pwdata[7:0];
				REG_EXIT_EV_MIN:     exit_ev_min_q     <= pwdata[7:0];
				REG_ENTER_NOISE_MIN: enter_noise_min_q <= pwdata[11:0];
				REG_EXIT_NOISE_MAX:  exit_noise_max_q  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ENTER_SCORE_MIN: prdata = {24'd0, enter_score_min_q};
			REG_EXIT_SCORE_MAX:  prdata = {24'd0, exit_score_max_q};
			REG_ENTER_ISO_MIN:   prdata = {16'd0, enter_iso_min_q};
			REG_EXIT_ISO_MAX:    prdata = {16'd0, exit_iso_max_q};
			REG_ENTER_EV_MAX:    prdata = {24'd0, enter_ev_max_q};
			REG_EXIT_EV_MIN:     prdata = {24'd0, exit_ev_min_q};
			REG_ENTER_NOISE_MIN: prdata = {20'd0, enter_noise_min_q};
			REG_EXIT_NOISE_MAX:  prdata = {20'd0, exit_noise_max_q};
			default:             prdata = '0;
		endcase
	end

	// input register
	logic              valid_s1;
	logic              meta_valid_s1, cam_switch_s1, thermal_off_s1, score_present_s1;
	logic [7:0]        dark_level_s1;
	logic [15:0]       iso_gain_s1;
	logic signed [7:0] exposure_ev_s1;
	logic [11:0]       noise_est_s1;

	logic out_valid_q;
	logic advance;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meta_valid_s1    <= meta_valid;
			cam_switch_s1    <= cam_switch;
			thermal_off_s1   <= thermal_off;
			score_present_s1 <= score_present;
			dark_level_s1    <= dark_level;
			iso_gain_s1      <= iso_gain;
			exposure_ev_s1   <= exposure_ev;
			noise_est_s1     <= noise_est;
		end
	end

	// decision state
	mode_t      mode_q, mode_d;
	logic [1:0] arm_q, arm_d, arm_inc;
	logic [3:0] exit_q, exit_d, exit_inc;
	logic [2:0] ramp_q, ramp_d, ramp_inc, exit_k;
	logic       byp_d;
	logic [8:0] str_d;
	logic       err_s1, dark, bright;

	assign err_s1 = ~meta_valid_s1 | cam_switch_s1 | thermal_off_s1;

	assign dark = (score_present_s1 && dark_level_s1 >= enter_score_min_q) ||
		(iso_gain_s1 >= enter_iso_min_q && exposure_ev_s1 <= enter_ev_max_q) ||
		(noise_est_s1 >= enter_noise_min_q);

	assign bright = (!score_present_s1 || dark_level_s1 <= exit_score_max_q) &&
		(iso_gain_s1 <= exit_iso_max_q) && (exposure_ev_s1 >= exit_ev_min_q) &&
		(noise_est_s1 <= exit_noise_max_q);

	assign arm_inc  = (arm_q == 2'd3) ? arm_q : arm_q + 2'd1;
	assign exit_inc = (exit_q == 4'd15) ? exit_q : exit_q + 4'd1;
	assign ramp_inc = (ramp_q >= RAMP_LEN) ? ramp_q : ramp_q + 3'd1;
	// ramp-down index, held at the lowest entry from the fifth bright frame on
	assign exit_k   = (exit_inc > 4'd5) ? 3'd4 : 3'(exit_inc - 4'd1);

	always_comb begin
		mode_d = mode_q;
		arm_d  = arm_q;
		exit_d = exit_q;
		ramp_d = ramp_q;
		byp_d  = 1'b1;
		str_d  = 9'd0;
		if (err_s1) begin
			mode_d = MODE_ERROR;
			arm_d  = 2'd0;
			exit_d = 4'd0;
			ramp_d = 3'd0;
		end else begin
			unique case (mode_q)
				MODE_BRIGHT, MODE_ARMING: begin
					if (!dark) begin
						mode_d = MODE_BRIGHT;
						arm_d  = 2'd0;
					end else begin
						mode_d = MODE_ARMING;
						arm_d  = arm_inc;
						if (arm_inc >= ARM_LIM) begin
							mode_d = MODE_RAMP;
							ramp_d = 3'd0;
							byp_d  = 1'b0;
							str_d  = ramp_strength(3'd0);
						end
					end
				end
				MODE_RAMP: begin
					ramp_d = ramp_inc;
					byp_d  = 1'b0;
					if (ramp_inc >= RAMP_LEN) begin
						mode_d = MODE_ACTIVE;
						str_d  = STRENGTH_FULL;
					end else begin
						str_d = ramp_strength(ramp_inc);
					end
				end
				MODE_ACTIVE, MODE_EXITP: begin
					if (!bright) begin
						mode_d = MODE_ACTIVE;
						exit_d = 4'd0;
						byp_d  = 1'b0;
						str_d  = STRENGTH_FULL;
					end else begin
						mode_d = MODE_EXITP;
						exit_d = exit_inc;
						if (exit_inc >= EXIT_LIM) begin
							mode_d = MODE_BRIGHT;
							arm_d  = 2'd0;
							exit_d = 4'd0;
							ramp_d = 3'd0;
						end else begin
							byp_d = 1'b0;
							str_d = ramp_strength(3'd4 - exit_k);
						end
					end
				end
				MODE_ERROR: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BRIGHT;
			arm_q  <= 2'd0;
			exit_q <= 4'd0;
			ramp_q <= 3'd0;
		end else if (advance) begin
			mode_q <= mode_d;
			arm_q  <= arm_d;
			exit_q <= exit_d;
			ramp_q <= ramp_d;
		end
	end

	// output register
	logic       bypass_q;
	logic [8:0] strength_q;
	mode_t      mode_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bypass_q   <= byp_d;
			strength_q <= str_d;
			mode_out_q <= mode_d;
		end
	end

	assign out_valid = out_valid_q;
	assign bypass    = bypass_q;
	assign strength  = strength_q;
	assign mode      = mode_out_q;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ERROR |=> mode_q == MODE_ERROR)
		else $error("error mode left without reset");

	a_err_entry: assert property (@(posedge clk) disable iff (!arst_n)
		advance && err_s1 |=> mode_q == MODE_ERROR && arm_q == 2'd0 &&
		exit_q == 4'd0 && ramp_q == 3'd0)
		else $error("bad metadata did not force error mode");

	a_bypass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bypass_q |-> strength_q == 9'd0)
		else $error("nonzero strength while bypassed");

	a_active_strength: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !bypass_q |-> strength_q != 9'd0 &&
		mode_out_q != MODE_ERROR && mode_out_q != MODE_BRIGHT)
		else $error("denoise enabled with no strength or in bypass mode");

endmodule

// ----- test/dark_scene_denoise_trigger_unit_tb.sv -----
// testbench for the dark scene denoise trigger: random frame traffic checked against a predictor
`timescale 1ns / 1ps
module dark_scene_denoise_trigger_unit_tb;
	import dsdt_pkg::*;

	localparam int ARM_N  = ARM_FRAMES_DEF;
	localparam int EXIT_N = EXIT_FRAMES_DEF;

	typedef struct {
		logic              meta_valid;
		logic              cam_switch;
		logic              thermal_off;
		logic              score_present;
		logic [7:0]        dark_level;
		logic [15:0]       iso_gain;
		logic signed [7:0] exposure_ev;
		logic [11:0]       noise_est;
	} frame_t;

	typedef struct {
		logic       bypass;
		logic [8:0] strength;
		mode_t      mode;
	} decision_t;

	class decision_board;
		logic [7:0]        enter_score_min, exit_score_max;
		logic [15:0]       enter_iso_min, exit_iso_max;
		logic signed [7:0] enter_ev_max, exit_ev_min;
		logic [11:0]       enter_noise_min, exit_noise_max;
		mode_t             mode_q;
		logic [1:0]        arm_cnt;
		logic [3:0]        exit_cnt;
		logic [2:0]        ramp_idx;
		decision_t         pending_decisions[$];
		int                failures;

		function new();
			enter_score_min = ENTER_SCORE_MIN_RST;
			exit_score_max  = EXIT_SCORE_MAX_RST;
			enter_iso_min   = ENTER_ISO_MIN_RST;
			exit_iso_max    = EXIT_ISO_MAX_RST;
			enter_ev_max    = ENTER_EV_MAX_RST;
			exit_ev_min     = EXIT_EV_MIN_RST;
			enter_noise_min = ENTER_NOISE_MIN_RST;
			exit_noise_max  = EXIT_NOISE_MAX_RST;
			mode_q   = MODE_BRIGHT;
			arm_cnt  = '0;
			exit_cnt = '0;
			ramp_idx = '0;
			failures = 0;
		endfunction

		// steps of 0.2 rounded to q1.8
		function logic [8:0] ramp_level(int i);
			return 9'((512 * (i + 1) + 5) / 10);
		endfunction

		function void set_threshold(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_ENTER_SCORE_MIN: enter_score_min = v[7:0];
				REG_EXIT_SCORE_MAX:  exit_score_max  = v[7:0];
				REG_ENTER_ISO_MIN:   enter_iso_min   = v[15:0];
				REG_EXIT_ISO_MAX:    exit_iso_max    = v[15:0];
				REG_ENTER_EV_MAX:    enter_ev_max    = v[7:0];
				REG_EXIT_EV_MIN:     exit_ev_min     = v[7:0];
				REG_ENTER_NOISE_MIN: enter_noise_min = v[11:0];
				REG_EXIT_NOISE_MAX:  exit_noise_max  = v[11:0];
				default: ;
			endcase
		endfunction

		function void take_frame(frame_t f);
			logic      dark, bright;
			int        k;
			decision_t d;
			d.bypass   = 1'b1;
			d.strength = '0;
			if (!f.meta_valid || f.cam_switch || f.thermal_off) begin
				mode_q   = MODE_ERROR;
				arm_cnt  = '0;
				exit_cnt = '0;
				ramp_idx = '0;
			end else if (mode_q != MODE_ERROR) begin
				dark = (f.score_present && f.dark_level >= enter_score_min) ||
					(f.iso_gain >= enter_iso_min && f.exposure_ev <= enter_ev_max) ||
					f.noise_est >= enter_noise_min;
				bright = (!f.score_present || f.dark_level <= exit_score_max) &&
					f.iso_gain <= exit_iso_max && f.exposure_ev >= exit_ev_min &&
					f.noise_est <= exit_noise_max;
				case (mode_q)
					MODE_BRIGHT, MODE_ARMING: begin
						if (!dark) begin
							mode_q  = MODE_BRIGHT;
							arm_cnt = '0;
						end else begin
							mode_q = MODE_ARMING;
							if (arm_cnt < 3)
								arm_cnt++;
							if (arm_cnt >= ARM_N) begin
								mode_q     = MODE_RAMP;
								ramp_idx   = '0;
								d.bypass   = 1'b0;
								d.strength = ramp_level(0);
							end
						end
					end
					MODE_RAMP: begin
						if (ramp_idx < RAMP_LEN)
							ramp_idx++;
						d.bypass = 1'b0;
						if (ramp_idx >= RAMP_LEN) begin
							mode_q     = MODE_ACTIVE;
							d.strength = STRENGTH_FULL;
						end else begin
							d.strength = ramp_level(int'(ramp_idx));
						end
					end
					MODE_ACTIVE, MODE_EXITP: begin
						if (!bright) begin
							mode_q     = MODE_ACTIVE;
							exit_cnt   = '0;
							d.bypass   = 1'b0;
							d.strength = STRENGTH_FULL;
						end else begin
							mode_q = MODE_EXITP;
							if (exit_cnt < 15)
								exit_cnt++;
							if (exit_cnt >= EXIT_N) begin
								mode_q   = MODE_BRIGHT;
								arm_cnt  = '0;
								exit_cnt = '0;
								ramp_idx = '0;
							end else begin
								// ramp down, floor at the lowest step
								k = exit_cnt - 1;
								if (k > RAMP_LEN - 1)
									k = RAMP_LEN - 1;
								d.bypass   = 1'b0;
								d.strength = ramp_level(RAMP_LEN - 1 - k);
							end
						end
					end
					default: ;
				endcase
			end
			d.mode = mode_q;
			pending_decisions.push_back(d);
		endfunction

		function void check_decision(logic b, logic [8:0] s, logic [2:0] m);
			decision_t e;
			if (pending_decisions.size() == 0) begin
				$error("decision with no frame pending: bypass %0d strength %0d mode %0d",
					b, s, m);
				failures++;
				return;
			end
			e = pending_decisions.pop_front();
			if (b !== e.bypass) begin
				$error("bypass: expected %0d, got %0d", e.bypass, b);
				failures++;
			end
			if (s !== e.strength) begin
				$error("strength: expected %0d, got %0d", e.strength, s);
				failures++;
			end
			if (m !== e.mode) begin
				$error("mode: expected %0d, got %0d", e.mode, m);
				failures++;
			end
		endfunction

		function int pending();
			return pending_decisions.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                meta_valid = 1'b1;
	logic                cam_switch = 1'b0;
	logic                thermal_off = 1'b0;
	logic                score_present = 1'b0;
	logic [7:0]          dark_level = '0;
	logic [15:0]         iso_gain = '0;
	logic signed [7:0]   exposure_ev = '0;
	logic [11:0]         noise_est = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                bypass;
	logic [8:0]          strength;
	logic [2:0]          mode;

	int            send_idle_pct = 21;
	int            recv_idle_pct = 57;
	decision_board sb;

	dark_scene_denoise_trigger_unit #(
		.ARM_FRAMES(ARM_N),
		.EXIT_FRAMES(EXIT_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.meta_valid(meta_valid),
		.cam_switch(cam_switch),
		.thermal_off(thermal_off),
		.score_present(score_present),
		.dark_level(dark_level),
		.iso_gain(iso_gain),
		.exposure_ev(exposure_ev),
		.noise_est(noise_est),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bypass(bypass),
		.strength(strength),
		.mode(mode)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic frame_t frame_of(input logic mv, input logic cs, input logic th,
		input logic sp, input logic [7:0] dl, input logic [15:0] iso, input int ev,
		input logic [11:0] ns);
		frame_t f;
		f.meta_valid    = mv;
		f.cam_switch    = cs;
		f.thermal_off   = th;
		f.score_present = sp;
		f.dark_level    = dl;
		f.iso_gain      = iso;
		f.exposure_ev   = 8'(ev);
		f.noise_est     = ns;
		return f;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.take_frame(frame_of(meta_valid, cam_switch, thermal_off, score_present,
				dark_level, iso_gain, int'(exposure_ev), noise_est));
		if (arst_n && out_valid && out_ready)
			sb.check_decision(bypass, strength, mode);
	end

	function automatic frame_t any_frame();
		return frame_of(1'b1, 1'b0, 1'b0, 1'($urandom_range(1)), 8'($urandom),
			16'($urandom), int'($signed(8'($urandom))), 12'($urandom));
	endfunction

	// one of the three dark criteria met, the rest random
	function automatic frame_t dark_frame();
		frame_t f;
		int     hi;
		f = any_frame();
		case ($urandom_range(2))
			0: begin
				f.score_present = 1'b1;
				f.dark_level = 8'(int'(sb.enter_score_min) +
					$urandom_range(255 - int'(sb.enter_score_min)));
			end
			1: begin
				hi = int'(sb.enter_ev_max);
				f.iso_gain = 16'(int'(sb.enter_iso_min) +
					$urandom_range(65535 - int'(sb.enter_iso_min)));
				f.exposure_ev = 8'(-128 + int'($urandom_range(hi + 128)));
			end
			default: begin
				f.noise_est = 12'(int'(sb.enter_noise_min) +
					$urandom_range(4095 - int'(sb.enter_noise_min)));
			end
		endcase
		return f;
	endfunction

	function automatic frame_t bright_frame();
		frame_t f;
		int     lo;
		lo = int'(sb.exit_ev_min);
		f = any_frame();
		f.dark_level  = 8'($urandom_range(int'(sb.exit_score_max)));
		f.iso_gain    = 16'($urandom_range(int'(sb.exit_iso_max)));
		f.exposure_ev = 8'(lo + int'($urandom_range(127 - lo)));
		f.noise_est   = 12'($urandom_range(int'(sb.exit_noise_max)));
		return f;
	endfunction

	task automatic send_frame(input frame_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		meta_valid    <= f.meta_valid;
		cam_switch    <= f.cam_switch;
		thermal_off   <= f.thermal_off;
		score_present <= f.score_present;
		dark_level    <= f.dark_level;
		iso_gain      <= f.iso_gain;
		exposure_ev   <= f.exposure_ev;
		noise_est     <= f.noise_est;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_threshold(idx, v);
		@(posedge clk);
	endtask

	task automatic program_thresholds(input logic [31:0] es, input logic [31:0] xs,
		input logic [31:0] ei, input logic [31:0] xi, input logic [31:0] ee,
		input logic [31:0] xe, input logic [31:0] en, input logic [31:0] xn);
		write_reg(REG_ENTER_SCORE_MIN, {24'd0, es[7:0]});
		write_reg(REG_EXIT_SCORE_MAX, {24'd0, xs[7:0]});
		write_reg(REG_ENTER_ISO_MIN, {16'd0, ei[15:0]});
		write_reg(REG_EXIT_ISO_MAX, {16'd0, xi[15:0]});
		write_reg(REG_ENTER_EV_MAX, {24'd0, ee[7:0]});
		write_reg(REG_EXIT_EV_MIN, {24'd0, xe[7:0]});
		write_reg(REG_ENTER_NOISE_MIN, {20'd0, en[11:0]});
		write_reg(REG_EXIT_NOISE_MAX, {20'd0, xn[11:0]});
	endtask

	task automatic program_random();
		program_thresholds($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
	endtask

	// runs of dark and bright frames drive the arm, ramp and exit sequences
	task automatic run_scenes(input int n_items);
		int sent;
		int pick;
		int len;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 45)
				len = $urandom_range(6, 1);
			else if (pick < 85)
				len = $urandom_range(14, 1);
			else
				len = $urandom_range(3, 1);
			for (int i = 0; i < len; i++) begin
				if (pick < 45)
					send_frame(dark_frame());
				else if (pick < 85)
					send_frame(bright_frame());
				else
					send_frame(any_frame());
			end
			sent += len;
		end
	endtask

	initial begin
		#400_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		frame_t f;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// arm on each dark criterion, ramp, exit with a broken run, then arming dropped
		send_frame(frame_of(1, 0, 0, 1, 255, 0, 127, 0));
		send_frame(frame_of(1, 0, 0, 0, 0, 65535, -128, 0));
		send_frame(frame_of(1, 0, 0, 0, 255, 0, 0, 4095));
		repeat (5) send_frame(frame_of(1, 0, 0, 1, 0, 0, 127, 0));
		send_frame(frame_of(1, 0, 0, 0, 200, 1201, 0, 0));
		repeat (4) send_frame(frame_of(1, 0, 0, 1, 115, 1200, -16, 61));
		send_frame(frame_of(1, 0, 0, 1, 116, 0, 0, 0));
		repeat (10) send_frame(frame_of(1, 0, 0, 0, 255, 0, -16, 0));
		send_frame(frame_of(1, 0, 0, 1, 179, 0, 0, 0));
		send_frame(frame_of(1, 0, 0, 1, 178, 1600, -23, 81));
		run_scenes(300);

		for (int blk = 1; blk < 6; blk++) begin
			wait_drained();
			if (blk == 2) begin
				send_idle_pct = 57;
				recv_idle_pct = 21;
			end else if (blk == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (blk)
				1, 4: program_random();
				// every frame both dark and bright
				2: program_thresholds(0, 255, 0, 65535, 127, -128, 0, 4095);
				// tightest thresholds
				3: program_thresholds(255, 0, 65535, 0, -128, 127, 4095, 0);
				default: program_thresholds(ENTER_SCORE_MIN_RST, EXIT_SCORE_MAX_RST,
					ENTER_ISO_MIN_RST, EXIT_ISO_MAX_RST, ENTER_EV_MAX_RST,
					EXIT_EV_MIN_RST, ENTER_NOISE_MIN_RST, EXIT_NOISE_MAX_RST);
			endcase
			run_scenes(300);
		end

		// sticky error: entered after a run of dark frames, held through every later frame
		repeat (4) send_frame(dark_frame());
		send_frame(frame_of(1, 1, 0, 1, 255, 65535, -128, 4095));
		send_frame(frame_of(0, 0, 0, 1, 0, 0, 127, 0));
		send_frame(frame_of(1, 0, 1, 0, 0, 0, 0, 0));
		send_frame(frame_of(1, 0, 0, 1, 255, 65535, -128, 4095));
		repeat (40) begin
			f = any_frame();
			f.meta_valid  = 1'($urandom_range(1));
			f.cam_switch  = 1'($urandom_range(1));
			f.thermal_off = 1'($urandom_range(1));
			send_frame(f);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/dsdt_pkg.sv
hw/rtl/dark_scene_denoise_trigger_unit.sv
test/dark_scene_denoise_trigger_unit_tb.sv
